>>> hw/rtl/kr_pkg.sv
package kr_pkg;

	// table geometry
	localparam int CAPACITY = 10;
	localparam int PAIRS = 3;
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int RW = 64;

	// command codes
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_READ   = 3'd1;
	localparam logic [2:0] CMD_DELETE = 3'd2;
	localparam logic [2:0] CMD_EXISTS = 3'd3;
	localparam logic [2:0] CMD_LIST   = 3'd4;

	typedef logic [7:0] byte_t;

	// one command request as taken from the ports
	typedef struct packed {
		logic [2:0]  cmd;
		byte_t       key;
		byte_t       year;
		byte_t [2:0] subj;
		byte_t [2:0] grade;
	} req_t;

	// insert-order memory access
	typedef struct packed {
		logic          we;
		logic [IW-1:0] waddr;
		logic [IW-1:0] wdata;
		logic [IW-1:0] raddr;
	} order_req_t;

	// record memory access
	typedef struct packed {
		logic          we;
		logic [IW-1:0] waddr;
		logic [RW-1:0] wdata;
		logic [IW-1:0] raddr;
	} store_req_t;

	// one result from the sequencer
	typedef struct packed {
		logic          valid;
		logic          ok;
		logic          last;
		logic [RW-1:0] rec;
		byte_t         lkey;
		logic [CW-1:0] used;
	} res_t;

	// pack a request into the stored record word
	function automatic logic [RW-1:0] pack_rec(req_t r);
		logic [RW-1:0] rec;
		rec = '0;
		rec[7:0] = r.key;
		rec[15:8] = r.year;
		for (int p = 0; p < 3; p++) begin
			if (p < PAIRS) begin
				rec[16 + 16*p +: 8] = r.subj[p];
				rec[24 + 16*p +: 8] = r.grade[p];
			end
		end
		return rec;
	endfunction

endpackage

>>> hw/rtl/keyed_record_table.sv
// Keyed record table: add, read, delete, exists and list over up to CAPACITY records.
// Add, unknown commands and commands on an empty table answer in the next cycle,
// busy stays low. Read/exists/delete scan the insert order newest first;
// delete then compacts the order memory, one entry a cycle; list emits one key a cycle.
// The scan rate is set by the chained insert-order and record memory reads.
// Reset empties the table at once; results come as one-cycle done strobes, never stalled.
module keyed_record_table
	import kr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [2:0]    cmd,
	input  logic [7:0]    key,
	input  logic [7:0]    year_in,
	input  logic [7:0]    subject_a_in,
	input  logic [7:0]    subject_b_in,
	input  logic [7:0]    subject_c_in,
	input  logic [7:0]    grade_a_in,
	input  logic [7:0]    grade_b_in,
	input  logic [7:0]    grade_c_in,
	output logic          done,
	output logic          ok,
	output logic [7:0]    year_out,
	output logic [7:0]    subject_a_out,
	output logic [7:0]    subject_b_out,
	output logic [7:0]    subject_c_out,
	output logic [7:0]    grade_a_out,
	output logic [7:0]    grade_b_out,
	output logic [7:0]    grade_c_out,
	output logic [7:0]    listed_key,
	output logic [CW-1:0] used_count,
	output logic          table_full,
	output logic          last
);

	req_t          req;
	order_req_t    order_req;
	store_req_t    store_req;
	logic [IW-1:0] order_rdata;
	logic [RW-1:0] store_rdata;
	res_t          res;

	logic          done_q;
	logic          ok_q;
	logic          last_q;
	logic [RW-1:0] rec_q;
	byte_t         lkey_q;
	logic [CW-1:0] count_out_q;
	logic          full_q;

	// request from the ports
	always_comb begin
		req.cmd = cmd;
		req.key = key;
		req.year = year_in;
		req.subj[0] = subject_a_in;
		req.subj[1] = subject_b_in;
		req.subj[2] = subject_c_in;
		req.grade[0] = grade_a_in;
		req.grade[1] = grade_b_in;
		req.grade[2] = grade_c_in;
	end

	kr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req         (req),
		.busy        (busy),
		.order_req   (order_req),
		.order_rdata (order_rdata),
		.store_req   (store_req),
		.store_rdata (store_rdata),
		.res         (res)
	);

	kr_ram #(
		.WIDTH (IW),
		.DEPTH (CAPACITY)
	) u_order_ram (
		.clk   (clk),
		.we    (order_req.we),
		.waddr (order_req.waddr),
		.wdata (order_req.wdata),
		.raddr (order_req.raddr),
		.rdata (order_rdata)
	);

	kr_ram #(
		.WIDTH (RW),
		.DEPTH (CAPACITY)
	) u_store_ram (
		.clk   (clk),
		.we    (store_req.we),
		.waddr (store_req.waddr),
		.wdata (store_req.wdata),
		.raddr (store_req.raddr),
		.rdata (store_rdata)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (res.valid) begin
			ok_q <= res.ok;
			last_q <= res.last;
			rec_q <= res.rec;
			lkey_q <= res.lkey;
			count_out_q <= res.used;
			full_q <= (res.used == CW'(CAPACITY));
		end
	end

	assign done = done_q;
	assign ok = ok_q;
	assign last = last_q;
	assign listed_key = lkey_q;
	assign used_count = count_out_q;
	assign table_full = full_q;
	assign year_out = rec_q[15:8];
	assign subject_a_out = rec_q[23:16];
	assign grade_a_out = rec_q[31:24];
	assign subject_b_out = rec_q[39:32];
	assign grade_b_out = rec_q[47:40];
	assign subject_c_out = rec_q[55:48];
	assign grade_c_out = rec_q[63:56];

endmodule

>>> hw/rtl/kr_ram.sv
module kr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/kr_ctrl.sv
module kr_ctrl
	import kr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  req_t          req,
	output logic          busy,
	output order_req_t    order_req,
	input  logic [IW-1:0] order_rdata,
	output store_req_t    store_req,
	input  logic [RW-1:0] store_rdata,
	output res_t          res
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_SHIFT  = 2'd2;

	logic [1:0]          state_q;
	logic [CW-1:0]       count_q;
	logic [CAPACITY-1:0] used_q;
	logic                issuing_q;
	logic                v_s1;
	logic                v_s2;
	logic                rdv_q;

	logic [2:0]    cmd_q;
	byte_t         key_q;
	logic [IW-1:0] issue_q;
	logic [IW-1:0] pos_s1;
	logic [IW-1:0] pos_s2;
	logic [IW-1:0] slot_s2;
	logic [CW-1:0] rd_q;
	logic [IW-1:0] wa_q;

	logic          accept;
	logic          is_full;
	logic [IW-1:0] free_idx;
	logic          key_hit;
	logic          s2_last;
	logic          shift_needed;

	// lowest slot not held by a live record
	function automatic logic [IW-1:0] lowest_free(logic [CAPACITY-1:0] used);
		logic [IW-1:0] idx;
		idx = '0;
		for (int s = CAPACITY - 1; s >= 0; s--) begin
			if (!used[s]) begin
				idx = IW'(s);
			end
		end
		return idx;
	endfunction

	assign busy = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);
	assign is_full = (count_q == CW'(CAPACITY));
	assign free_idx = lowest_free(used_q);
	assign key_hit = v_s2 && (store_rdata[7:0] == key_q);
	assign s2_last = (pos_s2 == '0);
	assign shift_needed = ((CW'(pos_s2) + CW'(1)) < count_q);

	// memory requests and result per state
	always_comb begin
		order_req = '0;
		store_req = '0;
		res = '0;
		res.used = count_q;
		res.last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.cmd)
						CMD_ADD: begin
							res.valid = 1'b1;
							if (!is_full) begin
								res.ok = 1'b1;
								res.used = count_q + CW'(1);
								store_req.we = 1'b1;
								store_req.waddr = free_idx;
								store_req.wdata = pack_rec(req);
								order_req.we = 1'b1;
								order_req.waddr = count_q[IW-1:0];
								order_req.wdata = free_idx;
							end
						end
						CMD_READ, CMD_DELETE, CMD_EXISTS, CMD_LIST: begin
							if (count_q == '0) begin
								res.valid = 1'b1;
							end
						end
						default: begin
							res.valid = 1'b1;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				order_req.raddr = issue_q;
				store_req.raddr = order_rdata;
				if (v_s2) begin
					if (cmd_q == CMD_LIST) begin
						res.valid = 1'b1;
						res.ok = 1'b1;
						res.lkey = store_rdata[7:0];
						res.last = s2_last;
					end else if (key_hit) begin
						if (cmd_q != CMD_DELETE) begin
							res.valid = 1'b1;
							res.ok = 1'b1;
							if (cmd_q == CMD_READ) begin
								res.rec = store_rdata;
							end
						end else if (!shift_needed) begin
							res.valid = 1'b1;
							res.ok = 1'b1;
							res.used = count_q - CW'(1);
						end
					end else if (s2_last) begin
						res.valid = 1'b1;
					end
				end
			end
			ST_SHIFT: begin
				order_req.raddr = rd_q[IW-1:0];
				if (rdv_q) begin
					order_req.we = 1'b1;
					order_req.waddr = wa_q;
					order_req.wdata = order_rdata;
				end
				if (rdv_q && (rd_q == count_q)) begin
					res.valid = 1'b1;
					res.ok = 1'b1;
					res.used = count_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			used_q <= '0;
			issuing_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			rdv_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_ADD: begin
								if (!is_full) begin
									count_q <= count_q + CW'(1);
									used_q[free_idx] <= 1'b1;
								end
							end
							CMD_READ, CMD_DELETE, CMD_EXISTS, CMD_LIST: begin
								if (count_q != '0) begin
									state_q <= ST_SEARCH;
									issuing_q <= 1'b1;
									v_s1 <= 1'b0;
									v_s2 <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if ((cmd_q != CMD_LIST) && key_hit) begin
						// newest match found: flush the scan
						issuing_q <= 1'b0;
						v_s1 <= 1'b0;
						v_s2 <= 1'b0;
						if (cmd_q == CMD_DELETE) begin
							used_q[slot_s2] <= 1'b0;
							if (shift_needed) begin
								state_q <= ST_SHIFT;
								rdv_q <= 1'b0;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						v_s1 <= issuing_q;
						issuing_q <= issuing_q && (issue_q != '0);
						v_s2 <= v_s1;
						if (v_s2 && s2_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SHIFT: begin
					if (rdv_q && (rd_q == count_q)) begin
						count_q <= count_q - CW'(1);
						rdv_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						rdv_q <= (rd_q != count_q);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan and shift pointers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q <= req.cmd;
					key_q <= req.key;
					issue_q <= IW'(count_q - CW'(1));
				end
			end
			ST_SEARCH: begin
				if (issuing_q) begin
					pos_s1 <= issue_q;
					issue_q <= issue_q - IW'(1);
				end
				pos_s2 <= pos_s1;
				slot_s2 <= order_rdata;
				rd_q <= CW'(pos_s2) + CW'(1);
			end
			ST_SHIFT: begin
				// move each later entry down one place
				if (rd_q != count_q) begin
					wa_q <= IW'(rd_q - CW'(1));
					rd_q <= rd_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> tb/keyed_record_table_checker.sv
`timescale 1ns / 1ps

// Watches the request and result ports of the record table, keeps a shadow table,
// and compares every result strobe with the oldest predicted result.
module keyed_record_table_checker
	import kr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  logic [2:0]    cmd,
	input  logic [7:0]    key,
	input  logic [7:0]    year_in,
	input  logic [7:0]    subject_a_in,
	input  logic [7:0]    subject_b_in,
	input  logic [7:0]    subject_c_in,
	input  logic [7:0]    grade_a_in,
	input  logic [7:0]    grade_b_in,
	input  logic [7:0]    grade_c_in,
	input  logic          done,
	input  logic          ok,
	input  logic [7:0]    year_out,
	input  logic [7:0]    subject_a_out,
	input  logic [7:0]    subject_b_out,
	input  logic [7:0]    subject_c_out,
	input  logic [7:0]    grade_a_out,
	input  logic [7:0]    grade_b_out,
	input  logic [7:0]    grade_c_out,
	input  logic [7:0]    listed_key,
	input  logic [CW-1:0] used_count,
	input  logic          table_full,
	input  logic          last,
	output int            mismatches,
	output int            awaited
);

	// one stored record
	typedef struct packed {
		byte_t       key;
		byte_t       year;
		byte_t [2:0] subj;
		byte_t [2:0] grade;
	} record_t;

	// one predicted result
	typedef struct packed {
		logic          ok;
		byte_t         year;
		byte_t [2:0]   subj;
		byte_t [2:0]   grade;
		byte_t         lkey;
		logic [CW-1:0] used;
		logic          full;
		logic          last;
	} outcome_t;

	// shadow table
	record_t       shadow_slots[CAPACITY];
	logic [IW-1:0] shadow_order[CAPACITY];
	int            held;

	outcome_t      awaited_results[$];

	// append status fields and queue the result
	function automatic void post_outcome(outcome_t o, logic fin);
		o.used = CW'(held);
		o.full = (held == CAPACITY);
		o.last = fin;
		awaited_results.push_back(o);
	endfunction

	// position in the order list of the newest record with key k, or -1
	function automatic int newest_with_key(byte_t k);
		for (int i = held - 1; i >= 0; i--) begin
			if (shadow_slots[shadow_order[i]].key == k)
				return i;
		end
		return -1;
	endfunction

	// lowest slot not named by a live record
	function automatic int first_free_slot();
		logic taken;
		for (int s = 0; s < CAPACITY; s++) begin
			taken = 1'b0;
			for (int i = 0; i < held; i++)
				if (shadow_order[i] == s)
					taken = 1'b1;
			if (!taken)
				return s;
		end
		return 0;
	endfunction

	// apply one accepted request to the shadow table and queue its results
	function automatic void apply_command(req_t r);
		outcome_t o;
		record_t  rec;
		int       pos;
		int       slot;
		o = '0;
		case (r.cmd)
			CMD_ADD: begin
				if (held < CAPACITY) begin
					slot = first_free_slot();
					rec = '0;
					rec.key = r.key;
					rec.year = r.year;
					for (int p = 0; p < 3; p++) begin
						if (p < PAIRS) begin
							rec.subj[p] = r.subj[p];
							rec.grade[p] = r.grade[p];
						end
					end
					shadow_slots[slot] = rec;
					shadow_order[held] = IW'(slot);
					held++;
					o.ok = 1'b1;
				end
				post_outcome(o, 1'b1);
			end
			CMD_READ, CMD_EXISTS: begin
				pos = newest_with_key(r.key);
				if (pos >= 0) begin
					o.ok = 1'b1;
					if (r.cmd == CMD_READ) begin
						rec = shadow_slots[shadow_order[pos]];
						o.year = rec.year;
						o.subj = rec.subj;
						o.grade = rec.grade;
					end
				end
				post_outcome(o, 1'b1);
			end
			CMD_DELETE: begin
				pos = newest_with_key(r.key);
				if (pos >= 0) begin
					// close the gap in the order list
					for (int i = pos; i + 1 < held; i++)
						shadow_order[i] = shadow_order[i + 1];
					held--;
					o.ok = 1'b1;
				end
				post_outcome(o, 1'b1);
			end
			CMD_LIST: begin
				if (held == 0) begin
					post_outcome(o, 1'b1);
				end else begin
					// newest key first, last marker on the oldest
					for (int i = held - 1; i >= 0; i--) begin
						o = '0;
						o.ok = 1'b1;
						o.lkey = shadow_slots[shadow_order[i]].key;
						post_outcome(o, i == 0);
					end
				end
			end
			default: begin
				post_outcome(o, 1'b1);
			end
		endcase
	endfunction

	function automatic void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endfunction

	// check one result strobe against the oldest prediction
	function automatic void check_result();
		outcome_t o;
		if (awaited_results.size() == 0) begin
			mismatches++;
			$display("%0t: result expected none actual ok=%0d key=%0d used=%0d last=%0d",
				$time, ok, listed_key, used_count, last);
			return;
		end
		o = awaited_results.pop_front();
		compare_field("ok", 8'(o.ok), 8'(ok));
		compare_field("year_out", o.year, year_out);
		compare_field("subject_a_out", o.subj[0], subject_a_out);
		compare_field("subject_b_out", o.subj[1], subject_b_out);
		compare_field("subject_c_out", o.subj[2], subject_c_out);
		compare_field("grade_a_out", o.grade[0], grade_a_out);
		compare_field("grade_b_out", o.grade[1], grade_b_out);
		compare_field("grade_c_out", o.grade[2], grade_c_out);
		compare_field("listed_key", o.lkey, listed_key);
		compare_field("used_count", 8'(o.used), 8'(used_count));
		compare_field("table_full", 8'(o.full), 8'(table_full));
		compare_field("last", 8'(o.last), 8'(last));
	endfunction

	req_t seen_req;
	assign seen_req = '{cmd: cmd, key: key, year: year_in,
		subj: {subject_c_in, subject_b_in, subject_a_in},
		grade: {grade_c_in, grade_b_in, grade_a_in}};

	// results first, then the request taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_results.delete();
			held = 0;
			mismatches = 0;
			awaited <= 0;
		end else begin
			if (done === 1'b1)
				check_result();
			if (start && busy === 1'b0)
				apply_command(seen_req);
			awaited <= awaited_results.size();
		end
	end

endmodule

>>> tb/keyed_record_table_tb.sv
`timescale 1ns / 1ps

// Drives table commands with random gaps; the checker predicts and compares.
module keyed_record_table_tb;
	import kr_pkg::*;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic [2:0]    cmd = CMD_LIST;
	logic [7:0]    key = '0;
	logic [7:0]    year_in = '0;
	logic [7:0]    subject_a_in = '0;
	logic [7:0]    subject_b_in = '0;
	logic [7:0]    subject_c_in = '0;
	logic [7:0]    grade_a_in = '0;
	logic [7:0]    grade_b_in = '0;
	logic [7:0]    grade_c_in = '0;
	logic          done;
	logic          ok;
	logic [7:0]    year_out;
	logic [7:0]    subject_a_out;
	logic [7:0]    subject_b_out;
	logic [7:0]    subject_c_out;
	logic [7:0]    grade_a_out;
	logic [7:0]    grade_b_out;
	logic [7:0]    grade_c_out;
	logic [7:0]    listed_key;
	logic [CW-1:0] used_count;
	logic          table_full;
	logic          last;
	int            mismatches;
	int            awaited;

	logic          no_gaps = 1'b0;

	keyed_record_table dut (.*);

	keyed_record_table_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// request with random payload
	function automatic req_t make_req(logic [2:0] c, byte_t k);
		req_t r;
		r.cmd = c;
		r.key = k;
		r.year = 8'($urandom_range(0, 255));
		for (int p = 0; p < 3; p++) begin
			r.subj[p] = 8'($urandom_range(0, 255));
			r.grade[p] = 8'($urandom_range(0, 255));
		end
		return r;
	endfunction

	// optional idle gap, then hold the request until it is taken
	task automatic issue(req_t r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= r.cmd;
		key <= r.key;
		year_in <= r.year;
		subject_a_in <= r.subj[0];
		subject_b_in <= r.subj[1];
		subject_c_in <= r.subj[2];
		grade_a_in <= r.grade[0];
		grade_b_in <= r.grade[1];
		grade_c_in <= r.grade[2];
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// hold off until every predicted result has come
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (awaited != 0);
	endtask

	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		req_t       r;
		int         pick;
		logic       filling;
		logic [2:0] c;
		byte_t      k;
		filling = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		issue(make_req(CMD_LIST, 8'h00));
		issue(make_req(CMD_READ, 8'h00));
		issue(make_req(CMD_EXISTS, 8'hFF));
		issue(make_req(CMD_DELETE, 8'h00));

		// field extremes
		r = make_req(CMD_ADD, 8'h00);
		r.year = '0;
		r.subj = '0;
		r.grade = '0;
		issue(r);
		r = make_req(CMD_ADD, 8'hFF);
		r.year = '1;
		r.subj = '1;
		r.grade = '1;
		issue(r);

		// fill up, with a repeated key
		for (int i = 0; i < 8; i++)
			issue(make_req(CMD_ADD, (i < 3) ? 8'h5A : 8'(i * 8'h11)));

		// refused add, then lookups on the full table
		issue(make_req(CMD_ADD, 8'h77));
		issue(make_req(CMD_LIST, 8'h00));
		issue(make_req(CMD_READ, 8'h5A));
		issue(make_req(CMD_EXISTS, 8'hFF));
		issue(make_req(CMD_DELETE, 8'h5A));
		issue(make_req(CMD_READ, 8'h5A));
		issue(make_req(CMD_DELETE, 8'hC3));
		issue(make_req(CMD_EXISTS, 8'hC3));
		issue(make_req(CMD_READ, 8'h00));
		issue(make_req(CMD_LIST, 8'h00));
		drain();

		// random traffic, swinging between filling and draining the table
		for (int i = 0; i < 250; i++) begin
			if (i % 25 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			if (i % 40 == 0)
				filling = ~filling;
			if (i % 60 == 30)
				drain();
			pick = $urandom_range(0, 99);
			if (filling) begin
				if (pick < 50)      c = CMD_ADD;
				else if (pick < 60) c = CMD_DELETE;
				else if (pick < 78) c = CMD_READ;
				else if (pick < 88) c = CMD_EXISTS;
				else                c = CMD_LIST;
			end else begin
				if (pick < 15)      c = CMD_ADD;
				else if (pick < 50) c = CMD_DELETE;
				else if (pick < 70) c = CMD_READ;
				else if (pick < 82) c = CMD_EXISTS;
				else                c = CMD_LIST;
			end
			// mostly keys from a small pool so lookups hit
			if ($urandom_range(0, 3) != 0)
				k = 8'($urandom_range(0, 15) * 17);
			else
				k = 8'($urandom_range(0, 255));
			issue(make_req(c, k));
		end

		// wait out the remaining results and any trailing compaction
		drain();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/kr_pkg.sv
hw/rtl/kr_ram.sv
hw/rtl/kr_ctrl.sv
hw/rtl/keyed_record_table.sv
tb/keyed_record_table_checker.sv
tb/keyed_record_table_tb.sv
